// ===== rtl/core/rrts_pkg.sv =====
// shared types and constants for the round robin task scheduler
// used by round_robin_task_scheduler and its testbench, no dependencies
package rrts_pkg;

  localparam int NUM_TASKS_DEF = 32;

  localparam int OP_W      = 3;
  localparam int ID_W      = 5;
  localparam int QUANT_W   = 8;
  localparam int CODE_W    = 2;
  localparam int TICK_W    = 32;
  localparam int STATUS_W  = 3;
  localparam int STAT_W    = STATUS_W + QUANT_W;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 48;
  localparam int RES_W      = CODE_W + ID_W + 1 + 1 + TICK_W;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  localparam logic [QUANT_W-1:0] QUANTUM_RST = 8'd10;

  typedef enum logic [OP_W-1:0] {
    OP_START = 3'd0,
    OP_TICK  = 3'd1,
    OP_YIELD = 3'd2,
    OP_ADD   = 3'd3,
    OP_TERM  = 3'd4,
    OP_BLOCK = 3'd5,
    OP_WAKE  = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_FREE    = 3'd0,
    ST_RUNNING = 3'd1,
    ST_READY   = 3'd2,
    ST_WAITING = 3'd3,
    ST_DYING   = 3'd4
  } status_t;

  typedef enum logic [CODE_W-1:0] {
    RC_OK          = 2'd0,
    RC_NOT_STARTED = 2'd1,
    RC_TERM_STAY   = 2'd2
  } code_t;

  // queue slots, indexed by status minus one
  localparam logic [1:0] Q_RUNNING = 2'd0;
  localparam logic [1:0] Q_READY   = 2'd1;
  localparam logic [1:0] Q_DYING   = 2'd3;

  // register byte address of quantum_ticks
  localparam logic [APB_AW-1:0] REG_QUANTUM = 3'd0;

  typedef enum logic [1:0] {
    RET_FIN,
    RET_PROMOTE,
    RET_DRAIN
  } ret_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_TICK,
    S_SCHED,
    S_SS_RD,
    S_SS_CHK,
    S_UL,
    S_UL_HEAD,
    S_WALK,
    S_WALK_RD,
    S_WALK_FIX,
    S_APPEND,
    S_RET,
    S_DRAIN,
    S_DRAIN_LNK,
    S_DRAIN_WR,
    S_FIN,
    S_FIN_RD,
    S_OUT
  } state_t;

  function automatic logic [1:0] q_of(input status_t s);
    logic [STATUS_W-1:0] d;
    d = STATUS_W'(s) - 3'd1;
    return d[1:0];
  endfunction

endpackage

// ===== rtl/core/round_robin_task_scheduler.sv =====
// round robin task scheduler top level: sequencer, queue pointers, apb register
// depends on rrts_pkg and rrts_ram
//
// Each operation word (op, task_id) yields exactly one result word. Task state
// (status and remaining quantum) sits in one ram with a valid bit per entry
// that reset clears, so no clearing pass is needed; the queue links sit in a
// second ram. Queue heads and tails are registers. One operation is worked
// on at a time by a sequencer that reads, modifies and writes the rams, each
// read registered in the ram. A tick that leaves the quantum running only
// rewrites the running task's entry. Moving a task that is not free into
// another queue unlinks it first, walking its links when it is not the
// head, and after a reschedule every task on the dying queue is freed in
// turn. The walk covers at most NUM_TASKS links, the drain NUM_TASKS tasks.
// The result word sits in an output register, so the next operation can be
// accepted while it waits.
// quantum_ticks is at byte address 0 of the apb port and should be written
// only while the block is idle.
module round_robin_task_scheduler #(
  parameter int NUM_TASKS = rrts_pkg::NUM_TASKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // op [2:0], task_id [7:3]
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [rrts_pkg::IN_DATA_W-1:0]  s_tdata,
  // result_code [1:0], running_id [6:2], running_valid [7], switched [8],
  // tick_total [40:9], zero fill [47:41]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [rrts_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rrts_pkg::APB_AW-1:0]     paddr,
  input  logic [rrts_pkg::APB_DW-1:0]     pwdata,
  output logic [rrts_pkg::APB_DW-1:0]     prdata,
  output logic                            pready
);

  localparam int TW = $clog2(NUM_TASKS);
  localparam int PW = TW + 1;
  localparam logic [PW-1:0] NIL = PW'(NUM_TASKS);

  rrts_pkg::state_t state, state_next;

  // operation context
  logic [rrts_pkg::OP_W-1:0]   op_q;
  logic [rrts_pkg::ID_W-1:0]   id_q;
  logic [TW-1:0]               cur, cur_was;
  logic                        started;
  rrts_pkg::code_t             code;
  logic                        term_self;
  logic [rrts_pkg::TICK_W-1:0] tick_cnt;
  logic [rrts_pkg::QUANT_W-1:0] quantum;

  // set_status call frame
  logic [TW-1:0]               ss_t;
  rrts_pkg::status_t           ss_s;
  rrts_pkg::ret_t              ret;
  logic [TW-1:0]               nx_q;
  rrts_pkg::status_t           ns;
  logic [rrts_pkg::QUANT_W-1:0] rem_q;

  // unlink walk
  logic [TW-1:0]               ul_t;
  logic [1:0]                  ul_q;
  logic [PW-1:0]               prev;
  logic [PW-1:0]               walk_n;
  logic [PW-1:0]               drain_n;

  logic [PW-1:0] head [4];
  logic [PW-1:0] tail [4];

  logic [rrts_pkg::RES_W-1:0]  res;

  // status ram
  logic                        s_we;
  logic [TW-1:0]               s_waddr, s_raddr;
  logic [rrts_pkg::STAT_W-1:0] s_wdata, s_rdata;
  logic [NUM_TASKS-1:0]        stat_vld;
  logic                        s_rvld;
  rrts_pkg::status_t           rd_status;
  logic [rrts_pkg::QUANT_W-1:0] rd_rem, rem_dec;

  // link ram
  logic                        l_we;
  logic [TW-1:0]               l_waddr, l_raddr, l_wdata, l_rdata;

  // dispatch decode
  logic                        id_ok;
  logic [TW-1:0]               id_t;
  logic                        d_ss, d_sched, d_tick, d_nst, d_start, d_self;
  rrts_pkg::status_t           d_ss_s, d_ns;

  // derived queue conditions
  logic [1:0]                  app_q;
  logic                        ul_is_head, ul_is_tail, walk_go, drain_go, ready_any;

  rrts_ram #(.WIDTH(rrts_pkg::STAT_W), .DEPTH(NUM_TASKS)) u_stat_ram (
    .clk  (clk),
    .we   (s_we),
    .waddr(s_waddr),
    .wdata(s_wdata),
    .raddr(s_raddr),
    .rdata(s_rdata)
  );

  rrts_ram #(.WIDTH(TW), .DEPTH(NUM_TASKS)) u_link_ram (
    .clk  (clk),
    .we   (l_we),
    .waddr(l_waddr),
    .wdata(l_wdata),
    .raddr(l_raddr),
    .rdata(l_rdata)
  );

  // an entry never written reads as a free task with the reset quantum
  assign rd_status = s_rvld ? rrts_pkg::status_t'(s_rdata[rrts_pkg::STAT_W-1:rrts_pkg::QUANT_W])
                            : rrts_pkg::ST_FREE;
  assign rd_rem    = s_rvld ? s_rdata[rrts_pkg::QUANT_W-1:0] : rrts_pkg::QUANTUM_RST;
  assign rem_dec   = rd_rem - 8'd1;

  assign id_ok = 32'(id_q) < 32'(NUM_TASKS);
  assign id_t  = TW'(id_q);

  assign app_q      = rrts_pkg::q_of(ss_s);
  assign ul_is_head = head[ul_q] == PW'(ul_t);
  assign ul_is_tail = tail[ul_q] == PW'(ul_t);
  assign walk_go    = walk_n < NIL && prev < NIL && prev != tail[ul_q];
  assign drain_go   = drain_n < NIL && head[rrts_pkg::Q_DYING] < NIL;
  assign ready_any  = head[rrts_pkg::Q_READY] < NIL;

  assign s_tready = state == rrts_pkg::S_IDLE;
  assign pready   = 1'b1;
  assign prdata   = (paddr == rrts_pkg::REG_QUANTUM) ? rrts_pkg::APB_DW'(quantum) : '0;

  // operation decode
  always_comb begin
    d_ss    = 1'b0;
    d_sched = 1'b0;
    d_tick  = 1'b0;
    d_nst   = 1'b0;
    d_start = 1'b0;
    d_self  = 1'b0;
    d_ss_s  = rrts_pkg::ST_READY;
    d_ns    = rrts_pkg::ST_READY;
    if (op_q == rrts_pkg::OP_START) begin
      if (!started && id_ok) begin
        d_start = 1'b1;
        d_ss    = 1'b1;
        d_ss_s  = rrts_pkg::ST_RUNNING;
      end
    end else if (!started) begin
      d_nst = 1'b1;
    end else begin
      case (op_q) inside
        rrts_pkg::OP_TICK: d_tick = 1'b1;
        rrts_pkg::OP_YIELD: d_sched = 1'b1;
        rrts_pkg::OP_ADD, rrts_pkg::OP_WAKE: begin
          d_ss = id_ok;
        end
        rrts_pkg::OP_TERM: begin
          if (id_ok && id_t == cur) begin
            d_sched = 1'b1;
            d_self  = 1'b1;
            d_ns    = rrts_pkg::ST_DYING;
          end else if (id_ok) begin
            d_ss   = 1'b1;
            d_ss_s = rrts_pkg::ST_DYING;
          end
        end
        rrts_pkg::OP_BLOCK: begin
          if (id_ok && id_t == cur) begin
            d_sched = 1'b1;
            d_ns    = rrts_pkg::ST_WAITING;
          end else if (id_ok) begin
            d_ss   = 1'b1;
            d_ss_s = rrts_pkg::ST_WAITING;
          end
        end
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rrts_pkg::S_IDLE:     if (s_tvalid) state_next = rrts_pkg::S_DISPATCH;
      rrts_pkg::S_DISPATCH: begin
        if (d_ss) state_next = rrts_pkg::S_SS_RD;
        else if (d_sched) state_next = rrts_pkg::S_SCHED;
        else if (d_tick) state_next = rrts_pkg::S_TICK;
        else state_next = rrts_pkg::S_FIN;
      end
      rrts_pkg::S_TICK:
        state_next = (rem_dec == '0) ? rrts_pkg::S_SCHED : rrts_pkg::S_FIN;
      rrts_pkg::S_SCHED:
        state_next = ready_any ? rrts_pkg::S_SS_RD : rrts_pkg::S_DRAIN;
      rrts_pkg::S_SS_RD:    state_next = rrts_pkg::S_SS_CHK;
      rrts_pkg::S_SS_CHK: begin
        if (rd_status == ss_s) state_next = rrts_pkg::S_RET;
        else if (rd_status != rrts_pkg::ST_FREE) state_next = rrts_pkg::S_UL;
        else state_next = rrts_pkg::S_APPEND;
      end
      rrts_pkg::S_UL: begin
        if (ul_is_head) begin
          state_next = ul_is_tail ? rrts_pkg::S_APPEND : rrts_pkg::S_UL_HEAD;
        end else begin
          state_next = rrts_pkg::S_WALK;
        end
      end
      rrts_pkg::S_UL_HEAD:  state_next = rrts_pkg::S_APPEND;
      rrts_pkg::S_WALK:
        state_next = walk_go ? rrts_pkg::S_WALK_RD : rrts_pkg::S_APPEND;
      rrts_pkg::S_WALK_RD: begin
        if (l_rdata == ul_t) begin
          state_next = ul_is_tail ? rrts_pkg::S_APPEND : rrts_pkg::S_WALK_FIX;
        end else begin
          state_next = rrts_pkg::S_WALK;
        end
      end
      rrts_pkg::S_WALK_FIX: state_next = rrts_pkg::S_APPEND;
      rrts_pkg::S_APPEND:   state_next = rrts_pkg::S_RET;
      rrts_pkg::S_RET: begin
        unique case (ret)
          rrts_pkg::RET_PROMOTE: state_next = rrts_pkg::S_SS_RD;
          rrts_pkg::RET_DRAIN:   state_next = rrts_pkg::S_DRAIN;
          default:               state_next = rrts_pkg::S_FIN;
        endcase
      end
      rrts_pkg::S_DRAIN: begin
        if (!drain_go) state_next = rrts_pkg::S_FIN;
        else if (tail[rrts_pkg::Q_DYING] == head[rrts_pkg::Q_DYING])
          state_next = rrts_pkg::S_DRAIN_WR;
        else state_next = rrts_pkg::S_DRAIN_LNK;
      end
      rrts_pkg::S_DRAIN_LNK: state_next = rrts_pkg::S_DRAIN_WR;
      rrts_pkg::S_DRAIN_WR:  state_next = rrts_pkg::S_DRAIN;
      rrts_pkg::S_FIN:       state_next = rrts_pkg::S_FIN_RD;
      rrts_pkg::S_FIN_RD:    state_next = rrts_pkg::S_OUT;
      rrts_pkg::S_OUT:       if (!m_tvalid || m_tready) state_next = rrts_pkg::S_IDLE;
      default:               state_next = rrts_pkg::S_IDLE;
    endcase
  end

  // ram control
  always_comb begin
    s_we    = 1'b0;
    s_waddr = cur;
    s_wdata = {rd_status, rem_dec};
    s_raddr = (state == rrts_pkg::S_SS_RD) ? ss_t : cur;
    l_we    = 1'b0;
    l_waddr = prev[TW-1:0];
    l_wdata = l_rdata;
    l_raddr = ul_t;
    unique case (state)
      rrts_pkg::S_TICK: begin
        s_we    = 1'b1;
        s_wdata = {rd_status, (rem_dec == '0) ? quantum : rem_dec};
      end
      rrts_pkg::S_WALK:     l_raddr = prev[TW-1:0];
      rrts_pkg::S_WALK_FIX: l_we = 1'b1;
      rrts_pkg::S_APPEND: begin
        s_we    = 1'b1;
        s_waddr = ss_t;
        s_wdata = {ss_s, rem_q};
        l_we    = tail[app_q] < NIL;
        l_waddr = tail[app_q][TW-1:0];
        l_wdata = ss_t;
      end
      rrts_pkg::S_DRAIN:    l_raddr = head[rrts_pkg::Q_DYING][TW-1:0];
      rrts_pkg::S_DRAIN_WR: begin
        s_we    = 1'b1;
        s_waddr = ul_t;
        s_wdata = {rrts_pkg::ST_FREE, quantum};
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= rrts_pkg::S_IDLE;
      started  <= 1'b0;
      cur      <= '0;
      tick_cnt <= '0;
      quantum  <= rrts_pkg::QUANTUM_RST;
      stat_vld <= '0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        head[i] <= NIL;
        tail[i] <= NIL;
      end
    end else begin
      state <= state_next;
      if (psel && penable && pwrite && paddr == rrts_pkg::REG_QUANTUM) begin
        quantum <= pwdata[rrts_pkg::QUANT_W-1:0];
      end
      if (s_we) stat_vld[s_waddr] <= 1'b1;
      if (state == rrts_pkg::S_OUT && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        rrts_pkg::S_DISPATCH: begin
          if (d_start) started <= 1'b1;
          if (d_tick) tick_cnt <= tick_cnt + 32'd1;
        end
        rrts_pkg::S_UL: begin
          if (ul_is_head && ul_is_tail) begin
            head[ul_q] <= NIL;
            tail[ul_q] <= NIL;
          end
        end
        rrts_pkg::S_UL_HEAD: head[ul_q] <= PW'(l_rdata);
        rrts_pkg::S_WALK_RD: begin
          if (l_rdata == ul_t && ul_is_tail) tail[ul_q] <= prev;
        end
        rrts_pkg::S_APPEND: begin
          if (!(tail[app_q] < NIL)) head[app_q] <= PW'(ss_t);
          tail[app_q] <= PW'(ss_t);
          if (ss_s == rrts_pkg::ST_RUNNING) cur <= ss_t;
        end
        rrts_pkg::S_DRAIN: begin
          if (drain_go && tail[rrts_pkg::Q_DYING] == head[rrts_pkg::Q_DYING]) begin
            head[rrts_pkg::Q_DYING] <= NIL;
            tail[rrts_pkg::Q_DYING] <= NIL;
          end
        end
        rrts_pkg::S_DRAIN_LNK: head[rrts_pkg::Q_DYING] <= PW'(l_rdata);
        default: ;
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    s_rvld <= stat_vld[s_raddr];
    case (state)
      rrts_pkg::S_IDLE: begin
        op_q      <= s_tdata[2:0];
        id_q      <= s_tdata[7:3];
        cur_was   <= cur;
        code      <= rrts_pkg::RC_OK;
        term_self <= 1'b0;
      end
      rrts_pkg::S_DISPATCH: begin
        if (d_nst) code <= rrts_pkg::RC_NOT_STARTED;
        term_self <= d_self;
        ns        <= d_ns;
        ss_t      <= id_t;
        ss_s      <= d_ss_s;
        ret       <= rrts_pkg::RET_FIN;
      end
      rrts_pkg::S_TICK: ns <= rrts_pkg::ST_READY;
      rrts_pkg::S_SCHED: begin
        nx_q    <= head[rrts_pkg::Q_READY][TW-1:0];
        ss_t    <= cur;
        ss_s    <= ns;
        ret     <= rrts_pkg::RET_PROMOTE;
        drain_n <= '0;
      end
      rrts_pkg::S_SS_CHK: begin
        rem_q <= rd_rem;
        ul_t  <= ss_t;
        ul_q  <= rrts_pkg::q_of(rd_status);
      end
      rrts_pkg::S_UL: begin
        prev   <= head[ul_q];
        walk_n <= '0;
      end
      rrts_pkg::S_WALK_RD: begin
        // keep the predecessor when the task is found, the link fix writes it
        if (l_rdata != ul_t) prev <= PW'(l_rdata);
        walk_n <= walk_n + 1'b1;
      end
      rrts_pkg::S_RET: begin
        if (ret == rrts_pkg::RET_PROMOTE) begin
          ss_t <= nx_q;
          ss_s <= rrts_pkg::ST_RUNNING;
          ret  <= rrts_pkg::RET_DRAIN;
        end
      end
      rrts_pkg::S_DRAIN:    ul_t <= head[rrts_pkg::Q_DYING][TW-1:0];
      rrts_pkg::S_DRAIN_WR: drain_n <= drain_n + 1'b1;
      rrts_pkg::S_FIN_RD: begin
        res <= {tick_cnt,
                cur != cur_was,
                started && rd_status == rrts_pkg::ST_RUNNING,
                rrts_pkg::ID_W'(cur),
                (term_self && cur == id_t) ? rrts_pkg::RC_TERM_STAY : code};
      end
      rrts_pkg::S_OUT: begin
        if (!m_tvalid || m_tready) m_tdata <= rrts_pkg::OUT_DATA_W'(res);
      end
      default: ;
    endcase
  end

  // checks
  a_started_sticks: assert property (@(posedge clk) disable iff (rst)
    started |=> started) else $error("started flag dropped");

  a_cur_in_range: assert property (@(posedge clk) disable iff (rst)
    PW'(cur) < NIL) else $error("current task out of range");

  a_ready_ptrs: assert property (@(posedge clk) disable iff (rst)
    (head[rrts_pkg::Q_READY] < NIL) == (tail[rrts_pkg::Q_READY] < NIL))
    else $error("ready queue head and tail disagree");

  a_dying_ptrs: assert property (@(posedge clk) disable iff (rst)
    (head[rrts_pkg::Q_DYING] < NIL) == (tail[rrts_pkg::Q_DYING] < NIL))
    else $error("dying queue head and tail disagree");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready) else $error("second word taken while busy");

endmodule

// ===== rtl/core/rrts_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module rrts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== tb/sv/tb_round_robin_task_scheduler.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the round robin task scheduler, stream and apb ports
// depends on rrts_pkg and round_robin_task_scheduler
module tb_round_robin_task_scheduler;

  localparam int NT        = rrts_pkg::NUM_TASKS_DEF;
  localparam int NIL       = NT;
  localparam int STALL_MAX = 5000;   // idle cycles before the watchdog fires
  localparam int SETTLE    = 300;    // covers a full link walk plus a long drain
  localparam int N_PHASES  = 6;
  localparam int PHASE_LEN = 250;

  // fields from the lowest bit up: code, run_id, run_ok, sw, ticks
  typedef struct packed {
    logic [31:0]       ticks;
    logic              sw;
    logic              run_ok;
    logic [4:0]        run_id;
    rrts_pkg::code_t   code;
  } sched_out_t;

  logic        clk, rst;
  logic        s_tvalid, s_tready;
  logic [rrts_pkg::IN_DATA_W-1:0]  s_tdata;    // op [2:0], task_id [7:3]
  logic        m_tvalid, m_tready;
  // code [1:0], id [6:2], valid [7], switched [8], ticks [40:9]
  logic [rrts_pkg::OUT_DATA_W-1:0] m_tdata;
  logic        psel, penable, pwrite;
  logic [rrts_pkg::APB_AW-1:0] paddr;
  logic [rrts_pkg::APB_DW-1:0] pwdata, prdata;
  logic        pready;

  round_robin_task_scheduler dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // scheduler mirror state
  logic [7:0]  quantum;
  logic        started;
  rrts_pkg::status_t status_of [NT];
  int          link_of [NT];
  int          head_of [4];
  int          tail_of [4];
  logic [7:0]  ticks_left [NT];
  int          cur_task;
  logic [31:0] tick_count;

  logic [7:0]  op_words [$];     // words waiting to be offered
  sched_out_t  results_due [$];  // predicted results in order

  int sender_idle, receiver_idle, phase;
  int words_in = 0;
  int words_out = 0;
  int errors = 0;
  int switches = 0;
  int term_stay = 0;
  int quanta_expired = 0;
  int hold_left, stall_cnt;
  bit hold_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // take a task out of whatever queue holds it
  function automatic void unlink_task(int t);
    int q, prev, n, nx;
    if (status_of[t] == rrts_pkg::ST_FREE) return;
    q = int'(status_of[t]) - 1;
    if (head_of[q] == t) begin
      if (tail_of[q] == t) begin
        head_of[q] = NIL;
        tail_of[q] = NIL;
      end else begin
        head_of[q] = link_of[t];
      end
      return;
    end
    prev = head_of[q];
    for (n = 0; n < NT && prev < NT && prev != tail_of[q]; n++) begin
      nx = link_of[prev];
      if (nx == t) begin
        if (tail_of[q] == t) tail_of[q] = prev;
        else link_of[prev] = link_of[t];
        return;
      end
      prev = nx;
    end
  endfunction

  // move a task to the tail of the queue for its new status
  function automatic void move_task(int t, rrts_pkg::status_t s);
    int q;
    q = int'(s) - 1;
    if (status_of[t] == s) return;
    if (status_of[t] != rrts_pkg::ST_FREE) unlink_task(t);
    status_of[t] = s;
    if (tail_of[q] < NT) link_of[tail_of[q]] = t;
    else head_of[q] = t;
    tail_of[q] = t;
    if (s == rrts_pkg::ST_RUNNING) cur_task = t;
  endfunction

  // rotate out the running task for the ready head if there is one, free the dying
  function automatic void reschedule(rrts_pkg::status_t s);
    int nx, n, d;
    nx = head_of[int'(rrts_pkg::ST_READY) - 1];
    if (nx < NT) begin
      move_task(cur_task, s);
      move_task(nx, rrts_pkg::ST_RUNNING);
    end
    for (n = 0; n < NT && head_of[int'(rrts_pkg::ST_DYING) - 1] < NT; n++) begin
      d = head_of[int'(rrts_pkg::ST_DYING) - 1];
      unlink_task(d);
      status_of[d] = rrts_pkg::ST_FREE;
      ticks_left[d] = quantum;
    end
  endfunction

  function automatic sched_out_t apply_op(logic [2:0] op, int id);
    sched_out_t r;
    int was;
    was = cur_task;
    r.code = rrts_pkg::RC_OK;
    if (op == rrts_pkg::OP_START) begin
      if (!started) begin
        started = 1'b1;
        move_task(id, rrts_pkg::ST_RUNNING);
      end
    end else if (!started) begin
      r.code = rrts_pkg::RC_NOT_STARTED;
    end else begin
      case (op) inside
        rrts_pkg::OP_TICK: begin
          tick_count++;
          ticks_left[cur_task] = ticks_left[cur_task] - 8'd1;
          if (ticks_left[cur_task] == 8'd0) begin
            ticks_left[cur_task] = quantum;
            quanta_expired++;
            reschedule(rrts_pkg::ST_READY);
          end
        end
        rrts_pkg::OP_YIELD: reschedule(rrts_pkg::ST_READY);
        rrts_pkg::OP_ADD, rrts_pkg::OP_WAKE: move_task(id, rrts_pkg::ST_READY);
        rrts_pkg::OP_TERM: begin
          if (id == cur_task) begin
            reschedule(rrts_pkg::ST_DYING);
            if (cur_task == id) r.code = rrts_pkg::RC_TERM_STAY;
          end else begin
            move_task(id, rrts_pkg::ST_DYING);
          end
        end
        rrts_pkg::OP_BLOCK: begin
          if (id == cur_task) reschedule(rrts_pkg::ST_WAITING);
          else move_task(id, rrts_pkg::ST_WAITING);
        end
        default: ;
      endcase
    end
    r.run_id = cur_task[4:0];
    r.run_ok = started && status_of[cur_task] == rrts_pkg::ST_RUNNING;
    r.sw     = cur_task != was;
    r.ticks  = tick_count;
    return r;
  endfunction

  // driver: predict each accepted word, then offer the next one
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        results_due.push_back(apply_op(s_tdata[2:0], int'(s_tdata[7:3])));
        words_in++;
      end
      if (!s_tvalid || s_tready) begin
        if (op_words.size() > 0 && $urandom_range(0, 99) >= sender_idle) begin
          s_tdata  <= op_words.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with one long hold-off to back the block up
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (!hold_done && phase == 1 && words_in > 500) begin
      hold_done <= 1'b1;
      hold_left <= 600;
      m_tready <= 1'b0;
    end else begin
      m_tready <= $urandom_range(0, 99) >= receiver_idle;
    end
  end

  // monitor: compare every result word against the oldest prediction
  always @(posedge clk) begin
    sched_out_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[rrts_pkg::RES_W-1:0];
      words_out++;
      if (results_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h", m_tdata);
      end else begin
        want = results_due.pop_front();
        if (got.sw) switches++;
        if (got.code == rrts_pkg::RC_TERM_STAY) term_stay++;
        if (got != want || m_tdata[rrts_pkg::OUT_DATA_W-1:rrts_pkg::RES_W] != '0) begin
          errors++;
          if (errors <= 10) begin
            $display("word %0d: want code %0d id %0d valid %b sw %b ticks %0d",
                     words_out, want.code, want.run_id, want.run_ok, want.sw, want.ticks);
            $display("  got code %0d id %0d valid %b sw %b ticks %0d fill %h",
                     got.code, got.run_id, got.run_ok, got.sw, got.ticks,
                     m_tdata[rrts_pkg::OUT_DATA_W-1:rrts_pkg::RES_W]);
          end
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_MAX) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  task automatic write_quantum(logic [7:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= rrts_pkg::REG_QUANTUM;
    pwdata  <= {24'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    quantum = v;
  endtask

  function automatic logic [7:0] op_word(rrts_pkg::op_t op, int id);
    return {id[4:0], op};
  endfunction

  // mostly ticks and moves among a handful of tasks, now and then any id
  function automatic logic [7:0] random_word();
    int r, id;
    rrts_pkg::op_t op;
    r  = $urandom_range(0, 99);
    id = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 7) : $urandom_range(0, NT - 1);
    if (r < 35)      op = rrts_pkg::OP_TICK;
    else if (r < 48) op = rrts_pkg::OP_YIELD;
    else if (r < 64) op = rrts_pkg::OP_ADD;
    else if (r < 74) op = rrts_pkg::OP_TERM;
    else if (r < 84) op = rrts_pkg::OP_BLOCK;
    else if (r < 96) op = rrts_pkg::OP_WAKE;
    else             op = rrts_pkg::OP_START;
    // terminate and block aim at the running task half the time
    if ((op == rrts_pkg::OP_TERM || op == rrts_pkg::OP_BLOCK) && $urandom_range(0, 1))
      id = cur_task;
    return op_word(op, id);
  endfunction

  task automatic wait_idle();
    while (op_words.size() > 0 || results_due.size() > 0 || s_tvalid) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    logic [7:0] qsel [N_PHASES];
    qsel = '{8'd1, 8'd255, 8'd3, 8'd2, 8'd1, 8'd5};
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    sender_idle = 0; receiver_idle = 0; phase = 0;
    quantum = rrts_pkg::QUANTUM_RST; started = 1'b0; cur_task = 0; tick_count = '0;
    for (int i = 0; i < NT; i++) begin
      status_of[i] = rrts_pkg::ST_FREE; link_of[i] = 0;
      ticks_left[i] = rrts_pkg::QUANTUM_RST;
    end
    for (int i = 0; i < 4; i++) begin
      head_of[i] = NIL; tail_of[i] = NIL;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: ops before start, repeated start, running task corner cases
    @(negedge clk);
    sender_idle = 8; receiver_idle = 53;
    op_words.push_back(op_word(rrts_pkg::OP_TICK, 0));
    op_words.push_back(op_word(rrts_pkg::OP_YIELD, 31));
    op_words.push_back(op_word(rrts_pkg::OP_ADD, 31));
    op_words.push_back(op_word(rrts_pkg::OP_TERM, 0));
    op_words.push_back(op_word(rrts_pkg::OP_BLOCK, 0));
    op_words.push_back(op_word(rrts_pkg::OP_WAKE, 31));
    op_words.push_back(op_word(rrts_pkg::OP_START, 31));
    op_words.push_back(op_word(rrts_pkg::OP_START, 0));     // ignored, already running
    op_words.push_back(op_word(rrts_pkg::OP_TERM, 31));     // none ready, stays running
    op_words.push_back(op_word(rrts_pkg::OP_YIELD, 0));     // none ready, no switch
    op_words.push_back(op_word(rrts_pkg::OP_ADD, 0));
    op_words.push_back(op_word(rrts_pkg::OP_ADD, 31));      // running task goes to ready
    op_words.push_back(op_word(rrts_pkg::OP_ADD, 0));       // same status, no-op
    op_words.push_back(op_word(rrts_pkg::OP_YIELD, 0));
    op_words.push_back(op_word(rrts_pkg::OP_BLOCK, 5));     // free task straight to waiting
    op_words.push_back(op_word(rrts_pkg::OP_WAKE, 5));
    op_words.push_back(op_word(rrts_pkg::OP_TERM, 0));      // terminate the running task, ready task 31 takes over
    op_words.push_back(op_word(rrts_pkg::OP_TERM, 31));     // terminate the running task again, task 5 takes over
    for (int i = 0; i < 10; i++) op_words.push_back(op_word(rrts_pkg::OP_TICK, 0));
    op_words.push_back(op_word(rrts_pkg::OP_BLOCK, 5));     // none ready, the running task stays running
    wait_idle();

    for (int p = 0; p < N_PHASES; p++) begin
      write_quantum(qsel[p]);
      @(negedge clk);
      phase = p;
      if (p < 2) begin
        sender_idle = 8; receiver_idle = 53;
      end else if (p < 4) begin
        sender_idle = 53; receiver_idle = 8;
      end else begin
        sender_idle = 0; receiver_idle = 0;
      end
      // periodically refill a pool of tasks so there is plenty to rotate
      for (int i = 0; i < PHASE_LEN; i++) begin
        if (i % 40 == 0)
          for (int k = 0; k < 4; k++)
            op_words.push_back(op_word(rrts_pkg::OP_ADD, $urandom_range(0, 7)));
        else
          op_words.push_back(random_word());
      end
      wait_idle();
    end

    $display("fed %0d op words, checked %0d results: %0d task switches, %0d quantum expiries,",
             words_in, words_out, switches, quanta_expired);
    $display("%0d terminates that left the task running, quantum settings 1 to 255", term_stay);
    if (errors == 0 && results_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("mismatches %0d, results still due %0d", errors, results_due.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
